// ----- rtl/core/bltsa_pkg.sv -----
// shared types, widths and constants for the block-linear texture swizzle address core
// used by bltsa_regs, bltsa_flow, bltsa_datapath and the top level
// no dependencies
`default_nettype none

package bltsa_pkg;

  // largest surface dimension in blocks, larger register values saturate here
  localparam int unsigned MAX_DIM = 16384;

  // field widths
  localparam int DIM_W   = 15;  // width / height registers
  localparam int BPB_W   = 5;   // bytes per block
  localparam int LG_W    = 3;   // gob height log2
  localparam int COORD_W = 14;  // block_x / block_y
  localparam int BASE_W  = 32;  // write base
  localparam int RD_W    = 32;  // read address
  localparam int WR_W    = 33;  // write address

  // internal datapath widths
  localparam int XB_W   = COORD_W + BPB_W;       // x * bytes
  localparam int WB_W   = DIM_W + BPB_W;         // w * bytes, also pitch
  localparam int YW_W   = COORD_W + DIM_W;       // y * w
  localparam int LIN_W  = YW_W + 1;              // y * w + x
  localparam int LINB_W = LIN_W + BPB_W;         // linear byte address
  localparam int GW_W   = WB_W - 6;              // gobs across one row
  localparam int HR_W   = DIM_W + 1;             // height rounded to block rows
  localparam int YG_W   = COORD_W - 3;           // y in units of gob rows
  localparam int T1M_W  = YG_W + GW_W;           // block row * gobs wide
  localparam int T1S_W  = T1M_W + 14;            // same, shifted by block bytes
  localparam int PLT_W  = COORD_W + WB_W;        // y * pitch
  localparam int ADDR_W = WB_W + HR_W;           // tiled address and surface size

  // pipeline depth
  localparam int NSTAGE = 5;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [2:0] REG_WIDTH      = 3'd0;
  localparam logic [2:0] REG_HEIGHT     = 3'd1;
  localparam logic [2:0] REG_BPB        = 3'd2;
  localparam logic [2:0] REG_PITCH_LIN  = 3'd3;
  localparam logic [2:0] REG_ROUND32    = 3'd4;
  localparam logic [2:0] REG_GOB_LG     = 3'd5;
  localparam logic [2:0] REG_TO_TILED   = 3'd6;
  localparam logic [2:0] REG_WRITE_BASE = 3'd7;

  // reset values
  localparam logic [DIM_W-1:0]  RST_WIDTH  = 15'd1;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 15'd1;
  localparam logic [BPB_W-1:0]  RST_BPB    = 5'd4;
  localparam logic [LG_W-1:0]   RST_GOB_LG = 3'd4;

  // gob geometry
  localparam logic [LG_W-1:0] LG_MAX     = 3'd5;
  localparam int              GOB_LOG2   = 9;   // 512 bytes per gob
  localparam int              GOBW_LOG2  = 6;   // 64 bytes per gob row
  localparam int              GOBH_LOG2  = 3;   // 8 rows per gob

  typedef struct packed {
    logic [DIM_W-1:0]  width_in_blocks;
    logic [DIM_W-1:0]  height_in_blocks;
    logic [BPB_W-1:0]  bytes_per_block;
    logic              pitch_linear_mode;
    logic              round_pitch_32;
    logic [LG_W-1:0]   gob_height_log2;
    logic              to_tiled;
    logic [BASE_W-1:0] write_base;
  } cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (32'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  function automatic logic [LG_W-1:0] sat_lg(input logic [LG_W-1:0] v);
    return (v > LG_MAX) ? LG_MAX : v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bltsa_regs.sv -----
// configuration register file behind an apb-style port
// depends on bltsa_pkg
`default_nettype none

module bltsa_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bltsa_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bltsa_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bltsa_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output bltsa_pkg::cfg_t                     cfg
);
  import bltsa_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_WIDTH:      cfg_nxt.width_in_blocks   = pwdata[DIM_W-1:0];
        REG_HEIGHT:     cfg_nxt.height_in_blocks  = pwdata[DIM_W-1:0];
        REG_BPB:        cfg_nxt.bytes_per_block   = pwdata[BPB_W-1:0];
        REG_PITCH_LIN:  cfg_nxt.pitch_linear_mode = pwdata[0];
        REG_ROUND32:    cfg_nxt.round_pitch_32    = pwdata[0];
        REG_GOB_LG:     cfg_nxt.gob_height_log2   = pwdata[LG_W-1:0];
        REG_TO_TILED:   cfg_nxt.to_tiled          = pwdata[0];
        REG_WRITE_BASE: cfg_nxt.write_base        = pwdata[BASE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_in_blocks   <= RST_WIDTH;
      cfg_r.height_in_blocks  <= RST_HEIGHT;
      cfg_r.bytes_per_block   <= RST_BPB;
      cfg_r.pitch_linear_mode <= 1'b0;
      cfg_r.round_pitch_32    <= 1'b0;
      cfg_r.gob_height_log2   <= RST_GOB_LG;
      cfg_r.to_tiled          <= 1'b1;
      cfg_r.write_base        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_WIDTH:      prdata = CFG_DATA_W'(cfg_r.width_in_blocks);
      REG_HEIGHT:     prdata = CFG_DATA_W'(cfg_r.height_in_blocks);
      REG_BPB:        prdata = CFG_DATA_W'(cfg_r.bytes_per_block);
      REG_PITCH_LIN:  prdata = CFG_DATA_W'(cfg_r.pitch_linear_mode);
      REG_ROUND32:    prdata = CFG_DATA_W'(cfg_r.round_pitch_32);
      REG_GOB_LG:     prdata = CFG_DATA_W'(cfg_r.gob_height_log2);
      REG_TO_TILED:   prdata = CFG_DATA_W'(cfg_r.to_tiled);
      REG_WRITE_BASE: prdata = CFG_DATA_W'(cfg_r.write_base);
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/bltsa_flow.sv -----
// valid bits and per-stage load enables for the address pipeline
// depends on bltsa_pkg
`default_nettype none

module bltsa_flow (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           out_stall,
  output logic                           in_stall,
  output logic                           out_valid,
  output logic [bltsa_pkg::NSTAGE-1:0]   ld
);
  import bltsa_pkg::*;

  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] v_nxt;
  logic [NSTAGE-1:0] adv;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    adv[NSTAGE-1] = !v_r[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (adv[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (adv[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ld        = adv;
  assign in_stall  = !adv[0];
  assign out_valid = v_r[NSTAGE-1];

`ifndef ASSERT_OFF
  // input held off only when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with an empty stage");

  // no transfer on either side keeps the item count
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && !in_stall) && !(out_valid && !out_stall))
    |=> ($countones(v_r) == $past($countones(v_r))))
    else $error("item count changed without a transfer");

  // input transfer alone adds exactly one item
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    ((in_valid && !in_stall) && !(out_valid && !out_stall))
    |=> ($countones(v_r) == $past($countones(v_r)) + 1))
    else $error("input transfer lost or duplicated");

  // output transfer alone removes exactly one item
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && !in_stall) && (out_valid && !out_stall))
    |=> ($countones(v_r) + 1 == $past($countones(v_r))))
    else $error("output transfer lost or duplicated");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/bltsa_datapath.sv -----
// five register stages computing linear and tiled byte addresses and the bounds flag
// depends on bltsa_pkg
`default_nettype none

module bltsa_datapath (
  input  logic                                clk,
  input  logic [bltsa_pkg::NSTAGE-1:0]        ld,
  input  bltsa_pkg::cfg_t                     cfg,
  input  logic [bltsa_pkg::COORD_W-1:0]       block_x,
  input  logic [bltsa_pkg::COORD_W-1:0]       block_y,
  output logic [bltsa_pkg::RD_W-1:0]          read_address,
  output logic [bltsa_pkg::WR_W-1:0]          write_address,
  output logic                                in_bounds
);
  import bltsa_pkg::*;

  localparam logic [WB_W-1:0] M31 = WB_W'(31);
  localparam logic [WB_W-1:0] M63 = WB_W'(63);

  logic [LG_W-1:0]  lg;
  logic [3:0]       blk_sh;
  logic [BPB_W-1:0] bpb;

  assign lg     = sat_lg(cfg.gob_height_log2);
  assign blk_sh = 4'(GOB_LOG2) + {1'b0, lg};
  assign bpb    = cfg.bytes_per_block;

  // stage 1: first products
  logic [DIM_W-1:0]   w_c;
  logic [XB_W-1:0]    xb_0;
  logic [WB_W-1:0]    wb_0;
  logic [YW_W-1:0]    yw_0;
  logic [COORD_W-1:0] s1_x_r;
  logic [COORD_W-1:0] s1_y_r;
  logic [XB_W-1:0]    s1_xb_r;
  logic [WB_W-1:0]    s1_wb_r;
  logic [YW_W-1:0]    s1_yw_r;

  assign w_c  = clamp_dim(cfg.width_in_blocks);
  assign xb_0 = XB_W'(block_x) * XB_W'(bpb);
  assign wb_0 = WB_W'(w_c) * WB_W'(bpb);
  assign yw_0 = YW_W'(block_y) * YW_W'(w_c);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_x_r  <= block_x;
      s1_y_r  <= block_y;
      s1_xb_r <= xb_0;
      s1_wb_r <= wb_0;
      s1_yw_r <= yw_0;
    end
  end

  // stage 2: pitch, gob count, rounded height, linear index
  logic [DIM_W-1:0]   h_c;
  logic [WB_W-1:0]    wb32;
  logic [WB_W-1:0]    wb64;
  logic [WB_W-1:0]    pitch_1;
  logic [HR_W-1:0]    rows_m1;
  logic [HR_W-1:0]    h_round;
  logic [HR_W-1:0]    hsel_1;
  logic [COORD_W-1:0] ysh_1;
  logic [COORD_W-1:0] s2_y_r;
  logic [XB_W-1:0]    s2_xb_r;
  logic [WB_W-1:0]    s2_pitch_r;
  logic [GW_W-1:0]    s2_gw_r;
  logic [HR_W-1:0]    s2_h_r;
  logic [LIN_W-1:0]   s2_lin_r;
  logic [YG_W-1:0]    s2_yg_r;

  assign h_c     = clamp_dim(cfg.height_in_blocks);
  assign wb32    = (s1_wb_r + M31) & ~M31;
  assign wb64    = s1_wb_r + M63;
  assign pitch_1 = cfg.pitch_linear_mode ? (cfg.round_pitch_32 ? wb32 : s1_wb_r)
                                         : (wb64 & ~M63);
  assign rows_m1 = HR_W'((9'd8 << lg) - 9'd1);
  assign h_round = (HR_W'(h_c) + rows_m1) & ~rows_m1;
  assign hsel_1  = cfg.pitch_linear_mode ? HR_W'(h_c) : h_round;
  assign ysh_1   = s1_y_r >> (4'(GOBH_LOG2) + {1'b0, lg});

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_y_r     <= s1_y_r;
      s2_xb_r    <= s1_xb_r;
      s2_pitch_r <= pitch_1;
      s2_gw_r    <= wb64[WB_W-1:GOBW_LOG2];
      s2_h_r     <= hsel_1;
      s2_lin_r   <= LIN_W'(s1_yw_r) + LIN_W'(s1_x_r);
      s2_yg_r    <= ysh_1[YG_W-1:0];
    end
  end

  // stage 3: second products
  logic [COORD_W-1:0] s3_y_r;
  logic [XB_W-1:0]    s3_xb_r;
  logic [PLT_W-1:0]   s3_tpl_r;
  logic [T1M_W-1:0]   s3_t1m_r;
  logic [LINB_W-1:0]  s3_lin_r;
  logic [ADDR_W-1:0]  s3_surf_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_y_r    <= s2_y_r;
      s3_xb_r   <= s2_xb_r;
      s3_tpl_r  <= PLT_W'(s2_y_r) * PLT_W'(s2_pitch_r);
      s3_t1m_r  <= T1M_W'(s2_yg_r) * T1M_W'(s2_gw_r);
      s3_lin_r  <= LINB_W'(s2_lin_r) * LINB_W'(bpb);
      s3_surf_r <= ADDR_W'(s2_pitch_r) * ADDR_W'(s2_h_r);
    end
  end

  // stage 4: tiled address
  logic [T1S_W-1:0]  t1_w;
  logic [ADDR_W-1:0] t1;
  logic [ADDR_W-1:0] t2;
  logic [YG_W-1:0]   bmask;
  logic [ADDR_W-1:0] t3;
  logic [8:0]        low_bits;
  logic [ADDR_W-1:0] tiled_bl;
  logic [ADDR_W-1:0] tiled_pl;
  logic [ADDR_W-1:0] s4_tiled_r;
  logic [LINB_W-1:0] s4_lin_r;
  logic [ADDR_W-1:0] s4_surf_r;

  assign t1_w  = T1S_W'(s3_t1m_r) << blk_sh;
  assign t1    = t1_w[ADDR_W-1:0];
  assign t2    = ADDR_W'(s3_xb_r >> GOBW_LOG2) << blk_sh;
  assign bmask = (YG_W'(1) << lg) - YG_W'(1);
  assign t3    = ADDR_W'(YG_W'(s3_y_r >> GOBH_LOG2) & bmask) << GOB_LOG2;
  // byte position inside one gob
  assign low_bits = {s3_xb_r[5], s3_y_r[2:1], s3_xb_r[4], s3_y_r[0], s3_xb_r[3:0]};
  // gob-in-block, gob column and in-gob terms occupy separate bits
  assign tiled_bl = t1 + (t2 | t3 | ADDR_W'(low_bits));
  assign tiled_pl = ADDR_W'(s3_tpl_r) + ADDR_W'(s3_xb_r);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_tiled_r <= cfg.pitch_linear_mode ? tiled_pl : tiled_bl;
      s4_lin_r   <= s3_lin_r;
      s4_surf_r  <= s3_surf_r;
    end
  end

  // stage 5: direction select, base offset and bounds check
  logic [ADDR_W-1:0] lin_4;
  logic [ADDR_W-1:0] rd_sel;
  logic [ADDR_W-1:0] wr_sel;
  logic [ADDR_W:0]   end_byte;

  assign lin_4    = ADDR_W'(s4_lin_r);
  assign rd_sel   = cfg.to_tiled ? lin_4 : s4_tiled_r;
  assign wr_sel   = cfg.to_tiled ? s4_tiled_r : lin_4;
  assign end_byte = {1'b0, s4_tiled_r} + (ADDR_W + 1)'(bpb);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      read_address  <= rd_sel[RD_W-1:0];
      write_address <= wr_sel[WR_W-1:0] + WR_W'(cfg.write_base);
      in_bounds     <= end_byte <= {1'b0, s4_surf_r};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/block_linear_texture_swizzle_addr_core.sv -----
// top level of the block-linear / pitch-linear texture swizzle address core
// depends on bltsa_pkg, bltsa_regs, bltsa_flow and bltsa_datapath
`default_nettype none

// Takes one texel-block coordinate per transfer and returns the source and destination
// byte addresses for a swizzle (to_tiled = 1, linear to tiled) or deswizzle copy, plus a
// flag saying whether the tiled bytes of that block lie inside the tiled surface. A new
// coordinate is taken every clock while in_stall is low: the datapath is a five-stage
// register pipeline with no feedback path, so throughput is one transfer per cycle
// while the output is not stalled, and every stage registers each coordinate. The
// multipliers sit in stages one and three, the gob address assembly in stage four, and
// the base add and bounds compare in the output stage. Each stage carries a valid bit;
// when the output is stalled, empty stages still fill, and the input is stalled only
// once all five hold an item. Registers sit behind an apb-style port at byte address
// 4*index, pready is always high, and every stage reads them live, so they must only
// be written while the pipeline is empty. Width and height above 16384 blocks
// saturate, and a gob height log2 above 5 acts as 5. There is no reset sweep; the core
// accepts input from the first cycle after reset.
module block_linear_texture_swizzle_addr_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // coordinate channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bltsa_pkg::COORD_W-1:0]       in_block_x,
  input  logic [bltsa_pkg::COORD_W-1:0]       in_block_y,
  // address channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bltsa_pkg::RD_W-1:0]          out_read_address,
  output logic [bltsa_pkg::WR_W-1:0]          out_write_address,
  output logic                                out_in_bounds,
  // register port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [bltsa_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [bltsa_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [bltsa_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);
  import bltsa_pkg::*;

  cfg_t              cfg;
  logic [NSTAGE-1:0] ld;

  // register file
  bltsa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // valid bits and stage enables, bubbles collapse under output stall
  bltsa_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ld        (ld)
  );

  // address arithmetic, the last stage is the output register
  bltsa_datapath u_dp (
    .clk           (clk),
    .ld            (ld),
    .cfg           (cfg),
    .block_x       (in_block_x),
    .block_y       (in_block_y),
    .read_address  (out_read_address),
    .write_address (out_write_address),
    .in_bounds     (out_in_bounds)
  );

endmodule

`default_nettype wire
